// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. The using module supplies clk and rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, disabled while reset is high.
`define APD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, including during reset.
`define APD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/apd_pkg.sv =====
// ---------------------------------------------------------------------------
// apd_pkg
// Types and constants shared by the amplitude PID controller with deadband.
// ---------------------------------------------------------------------------
package apd_pkg;

  localparam int CH_W      = 3;
  localparam int TGT_W     = 32;
  localparam int ERR_W     = TGT_W + 1;
  localparam int INT_W     = ERR_W + 1;
  localparam int GAIN_W    = 20;
  localparam int THR_W     = 16;
  localparam int LIM_W     = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int REL_SHIFT = 16;
  localparam int LHS_W     = ERR_W + REL_SHIFT;
  localparam int RHS_W     = THR_W + TGT_W;
  localparam int PROD_W    = GAIN_W + 1 + INT_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DRV_W     = 32;
  localparam int STAT_W    = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_ADJUST = 2'd0,
    ST_HOLD   = 2'd1,
    ST_RESET  = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_REL_ERR_MAX = 3'd3,
    CFG_REL_ERR_MIN = 3'd4,
    CFG_INT_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [CH_W-1:0]  channel;
    logic signed [TGT_W-1:0] target;
    logic signed [TGT_W-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [DRV_W-1:0]  drive;
    logic        [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [THR_W-1:0]  rel_err_max;
    logic [THR_W-1:0]  rel_err_min;
    logic [LIM_W-1:0]  integral_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:         20'd13107,
    gain_i:         20'd1311,
    gain_d:         20'd0,
    rel_err_max:    16'd13107,
    rel_err_min:    16'd7,
    integral_limit: 31'd65536
  };

  // Per-channel integrator state, read and written in the update stage.
  typedef struct packed {
    logic signed [INT_W-1:0] integ;
    logic signed [ERR_W-1:0] prev;
  } ip_entry_t;

  localparam int IP_W = $bits(ip_entry_t);

  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] integ;
    logic signed [INT_W-1:0] deriv;
  } pid_stage_t;

  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [PROD_W-1:0] pp;
    logic signed [PROD_W-1:0] pi;
    logic signed [PROD_W-1:0] pd;
  } prod_stage_t;

endpackage

// ===== rtl/core/apd_ram.sv =====
// ---------------------------------------------------------------------------
// apd_ram
// Per-channel state memory: registered read, one write port, entries read as
// zero until first written, and a bypass for a same-edge write and read.
// ---------------------------------------------------------------------------
module apd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] mem_q;
  logic [WIDTH-1:0] byp_q;
  logic             vld_q;
  logic             hit_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
      byp_q <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (re) begin
      vld_q <= vld[raddr];
      hit_q <= we && (waddr == raddr);
    end
  end

  assign rdata = hit_q ? byp_q : (vld_q ? mem_q : '0);

  `include "assert_macros.svh"

  `APD_ASSERT(a_ram_bypass, !rst && re && we && (waddr == raddr) |=> rdata == $past(wdata), "write-to-read bypass lost the new data")

endmodule

// ===== rtl/core/apd_front.sv =====
// ---------------------------------------------------------------------------
// apd_front
// Accepts samples, reads the channel's integrator state, classifies the
// relative error and updates the integral and previous error.
// ---------------------------------------------------------------------------
module apd_front #(
  parameter int CHANNELS = 8,
  parameter int AW       = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                sample_valid,
  input  apd_pkg::sample_t    sample,
  input  apd_pkg::cfg_t       cfg,
  output apd_pkg::pid_stage_t s2,
  output logic [AW-1:0]       s2_idx
);

  import apd_pkg::*;

  logic [CH_W-1:0]         ch_rem;
  logic [AW-1:0]           in_idx;
  logic                    s1_valid;
  logic [AW-1:0]           s1_idx;
  logic signed [TGT_W-1:0] s1_target;
  logic signed [TGT_W-1:0] s1_measured;

  logic [IP_W-1:0]         ip_rdata;
  ip_entry_t               ip_cur;
  ip_entry_t               ip_next;
  logic                    ip_we;

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        abs_err;
  logic [TGT_W-1:0]        abs_tgt;
  logic [LHS_W-1:0]        lhs;
  logic [RHS_W-1:0]        rhs_max;
  logic [RHS_W-1:0]        rhs_min;
  status_t                 cls;

  logic signed [INT_W-1:0] lim;
  logic signed [INT_W-1:0] clamped;
  logic signed [INT_W-1:0] integ_new;
  logic signed [INT_W-1:0] deriv;

  pid_stage_t              stage_next;
  pid_stage_t              s2_q;

  // The channel number is folded into range by repeated subtraction.
  always_comb begin
    ch_rem = sample.channel;
    for (int k = 0; k < (1 << CH_W) - 1; k++) begin
      if (32'(ch_rem) >= CHANNELS) begin
        ch_rem = ch_rem - CH_W'(CHANNELS);
      end
    end
  end

  assign in_idx = AW'(ch_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx      <= in_idx;
      s1_target   <= sample.target;
      s1_measured <= sample.measured;
    end
  end

  apd_ram #(
    .WIDTH (IP_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ip_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (adv),
    .raddr (in_idx),
    .rdata (ip_rdata),
    .we    (ip_we),
    .waddr (s1_idx),
    .wdata (ip_next)
  );

  assign ip_cur = ip_entry_t'(ip_rdata);

  // Relative error test without a divide: |err| * 2^16 against thr * |target|.
  assign err     = ERR_W'(s1_target) - ERR_W'(s1_measured);
  assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign abs_tgt = s1_target[TGT_W-1] ? TGT_W'(-s1_target) : TGT_W'(s1_target);
  assign lhs     = {abs_err, {REL_SHIFT{1'b0}}};
  assign rhs_max = RHS_W'(cfg.rel_err_max) * RHS_W'(abs_tgt);
  assign rhs_min = RHS_W'(cfg.rel_err_min) * RHS_W'(abs_tgt);

  always_comb begin
    if (s1_target == '0) begin
      cls = ST_ZERO;
    end else if (lhs > LHS_W'(rhs_max)) begin
      cls = ST_RESET;
    end else if (lhs > LHS_W'(rhs_min)) begin
      cls = ST_ADJUST;
    end else begin
      cls = ST_HOLD;
    end
  end

  assign lim = $signed({{(INT_W-LIM_W){1'b0}}, cfg.integral_limit});

  always_comb begin
    if (ip_cur.integ > lim) begin
      clamped = lim;
    end else if (ip_cur.integ < -lim) begin
      clamped = -lim;
    end else begin
      clamped = ip_cur.integ;
    end
  end

  assign integ_new = clamped + INT_W'(err);
  assign deriv     = INT_W'(err) - INT_W'(ip_cur.prev);

  always_comb begin
    ip_next = ip_cur;
    if (cls == ST_ADJUST) begin
      ip_next.integ = integ_new;
      ip_next.prev  = err;
    end else begin
      ip_next.integ = '0;
    end
  end

  assign ip_we = adv && s1_valid && ((cls == ST_ADJUST) || (cls == ST_RESET));

  always_comb begin
    stage_next.valid  = s1_valid;
    stage_next.status = cls;
    stage_next.err    = err;
    stage_next.integ  = (cls == ST_ADJUST) ? integ_new : '0;
    stage_next.deriv  = deriv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_q.valid <= 1'b0;
    end else if (adv) begin
      s2_q   <= stage_next;
      s2_idx <= s1_idx;
    end
  end

  assign s2 = s2_q;

  `include "assert_macros.svh"

  `APD_ASSERT(a_reset_clears_integ, !rst && adv && s1_valid && (cls == ST_RESET) |=> s2_q.integ == '0, "too-large error did not clear the integral")

endmodule

// ===== rtl/core/apd_back.sv =====
// ---------------------------------------------------------------------------
// apd_back
// Forms the three PID products, sums, scales and saturates them, keeps the
// held output per channel and registers the result.
// ---------------------------------------------------------------------------
module apd_back #(
  parameter int CHANNELS  = 8,
  parameter int AW        = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  apd_pkg::cfg_t       cfg,
  input  apd_pkg::pid_stage_t s2,
  input  logic [AW-1:0]       s2_idx,
  output logic                result_valid,
  output apd_pkg::result_t    result
);

  import apd_pkg::*;

  logic signed [GAIN_W:0]   gp_s;
  logic signed [GAIN_W:0]   gi_s;
  logic signed [GAIN_W:0]   gd_s;
  prod_stage_t              prod_next;
  prod_stage_t              s3_q;
  logic [AW-1:0]            s3_idx;

  logic [DRV_W-1:0]         h_rdata;
  logic [DRV_W-1:0]         h_wdata;
  logic                     h_we;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-DRV_W:0]     hi_bits;
  logic signed [DRV_W-1:0]  pid_out;
  logic signed [DRV_W-1:0]  drive_next;
  result_t                  res_q;
  logic                     res_valid_q;

  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});

  always_comb begin
    prod_next.valid  = s2.valid;
    prod_next.status = s2.status;
    prod_next.pp     = gp_s * s2.err;
    prod_next.pi     = gi_s * s2.integ;
    prod_next.pd     = gd_s * s2.deriv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_q.valid <= 1'b0;
    end else if (adv) begin
      s3_q   <= prod_next;
      s3_idx <= s2_idx;
    end
  end

  // Held output is read at the edge that loads the product stage, later than the
  // integrator state, so it lines up with the stage where the new drive is known.
  apd_ram #(
    .WIDTH (DRV_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_held_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (adv),
    .raddr (s2_idx),
    .rdata (h_rdata),
    .we    (h_we),
    .waddr (s3_idx),
    .wdata (h_wdata)
  );

  assign sum     = SUM_W'(s3_q.pp) + SUM_W'(s3_q.pi) + SUM_W'(s3_q.pd);
  assign shifted = sum >>> FRAC_BITS;
  assign hi_bits = shifted[SUM_W-1:DRV_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      pid_out = shifted[DRV_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      pid_out = {1'b1, {(DRV_W-1){1'b0}}};
    end else begin
      pid_out = {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  always_comb begin
    case (s3_q.status)
      ST_ADJUST: drive_next = pid_out;
      ST_HOLD:   drive_next = $signed(h_rdata);
      default:   drive_next = '0;
    endcase
  end

  assign h_we    = adv && s3_q.valid &&
                   ((s3_q.status == ST_ADJUST) || (s3_q.status == ST_RESET));
  assign h_wdata = (s3_q.status == ST_ADJUST) ? pid_out : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q  <= s3_q.valid;
      res_q.drive  <= drive_next;
      res_q.status <= s3_q.status;
    end
  end

  assign result_valid = res_valid_q;
  assign result       = res_q;

  `include "assert_macros.svh"

  `APD_ASSERT(a_zero_setpoint_drive, !rst && adv && s3_q.valid && (s3_q.status == ST_ZERO) |=> result_valid && (result.drive == '0), "zero setpoint gave a nonzero drive")

endmodule

// ===== rtl/core/amplitude_pid_deadband_top.sv =====
// ---------------------------------------------------------------------------
// amplitude_pid_deadband_top
// Multi-channel amplitude PID controller with deadband and anti-windup.
// ---------------------------------------------------------------------------
// Samples arrive on the sample channel (valid/ready), each naming a channel
// and carrying a setpoint and a measured amplitude in signed fixed point.
// One result transaction (drive and status) leaves on the result channel for
// every sample transaction, in order.
// A sample passes the input, update-stage, product and result registers, and
// one sample is taken every cycle while the pipeline is not held, also back
// to back on the same channel. The integrator-state memory is read at the
// accepting edge; the update stage, the multiplier stage and the sum/saturate
// stage then follow in turn, the last one feeding the result register.
// Per-channel state sits in two registered-read memories; a write-to-read
// bypass covers consecutive samples for one channel.
// Configuration registers are written through cfg_wr/cfg_index/cfg_data; the user
// must write them only while no transaction is in flight (the block does not enforce it).
// Reset loads the default configuration and makes every channel's state read
// as zero at once; no clearing pass is needed and samples are taken in the
// first cycle after reset.
// While a result waits and result_ready is low, the whole pipeline holds and
// sample_ready is low until the result is taken.
// ---------------------------------------------------------------------------
module amplitude_pid_deadband_top #(
  parameter int CHANNELS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  apd_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output apd_pkg::result_t                result,
  input  logic                            cfg_wr,
  input  logic [apd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apd_pkg::CFG_W-1:0]       cfg_data
);

  import apd_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t        cfg_q;
  logic        adv;
  pid_stage_t  s2;
  logic [AW-1:0] s2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_GAIN_P:      cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:      cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:      cfg_q.gain_d         <= cfg_data[GAIN_W-1:0];
        CFG_REL_ERR_MAX: cfg_q.rel_err_max    <= cfg_data[THR_W-1:0];
        CFG_REL_ERR_MIN: cfg_q.rel_err_min    <= cfg_data[THR_W-1:0];
        CFG_INT_LIMIT:   cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the result register can take data.
  assign adv          = !result_valid || result_ready;
  assign sample_ready = !rst && adv;

  apd_front #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .sample_valid (sample_valid && sample_ready),
    .sample       (sample),
    .cfg          (cfg_q),
    .s2           (s2),
    .s2_idx       (s2_idx)
  );

  apd_back #(
    .CHANNELS  (CHANNELS),
    .AW        (AW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .cfg          (cfg_q),
    .s2           (s2),
    .s2_idx       (s2_idx),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
